// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bdq_pkg.sv =====
// Package for the bounded double-ended queue: widths, opcodes, status codes
// and the per-cell operation type. No dependencies.
package bdq_pkg;

    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = 5;   // width of capacity and occupancy
    localparam int MAX_CAP     = 31;  // largest capacity the register can hold
    localparam int DEPTH_DEF   = 16;
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Request opcodes; any code with the top bit set acts as clear
    localparam logic [FUNC_W-1:0] FUNC_PUSH_L = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_R = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_L  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_R  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    // What a storage cell loads on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

endpackage

// ===== hw/rtl/bounded_double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values, built as a row of
// storage cells with the leftmost entry always in cell 0. For each transaction
// the whole row shifts, one cell loads or the row holds at the clock edge,
// and the result appears in an output register in the cycle after acceptance.
// A request is accepted while that register is empty or its result is taken
// at the same edge; while a result waits under output stall the request
// channel stalls, so without output stall one request is accepted per cycle.
// The row has min(DEPTH, 31) cells; the effective capacity is the smaller of
// the capacity register and that cell count. No clearing pass after reset.
// Depends on bdq_pkg, bdq_cell and assert_macros.svh.
`include "assert_macros.svh"

module bounded_double_ended_queue #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bdq_pkg::FUNC_W-1:0]    i_func,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_push_value,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bdq_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_at_right,
    output logic signed [bdq_pkg::DATA_W-1:0] o_item_value,
    output logic [bdq_pkg::CNT_W-1:0]     o_occupancy,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdq_pkg::CNT_W-1:0]     i_cfg_capacity
);

    localparam int NCELL = (DEPTH < bdq_pkg::MAX_CAP) ? DEPTH : bdq_pkg::MAX_CAP;
    localparam int IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [bdq_pkg::CNT_W-1:0] NCELL_C = bdq_pkg::CNT_W'(NCELL);

    logic [bdq_pkg::CNT_W-1:0]    r_capacity;
    logic [bdq_pkg::CNT_W-1:0]    r_count;
    logic [bdq_pkg::CNT_W-1:0]    n_count;
    logic                         r_out_valid;
    logic [bdq_pkg::STATUS_W-1:0] r_status;
    logic [bdq_pkg::STATUS_W-1:0] n_status;
    logic                         r_at_right;
    logic                         n_at_right;
    logic [bdq_pkg::DATA_W-1:0]   r_item;
    logic [bdq_pkg::DATA_W-1:0]   n_item;

    logic [bdq_pkg::CNT_W-1:0]    w_cap_eff;
    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_push_ok;
    logic [bdq_pkg::CNT_W-1:0]    w_count_inc;
    logic [bdq_pkg::CNT_W-1:0]    w_last;
    logic [IDX_W-1:0]             w_last_idx;
    logic [bdq_pkg::DATA_W-1:0]   w_cell_data [NCELL];
    bdq_pkg::t_cell_op            w_op [NCELL];

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bdq_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    // Full / empty and the rightmost occupied cell
    assign w_cap_eff   = (r_capacity > NCELL_C) ? NCELL_C : r_capacity;
    assign w_full      = (r_count >= w_cap_eff);
    assign w_empty     = (r_count == '0);
    assign w_count_inc = r_count + bdq_pkg::CNT_W'(1);
    assign w_last      = r_count - bdq_pkg::CNT_W'(1);
    assign w_last_idx  = w_last[IDX_W-1:0];

    // Request decode: result fields and next count
    always_comb begin
        n_count    = r_count;
        n_status   = bdq_pkg::ST_CLEARED;
        n_at_right = 1'b0;
        n_item     = '0;
        case (i_func)
            bdq_pkg::FUNC_PUSH_L, bdq_pkg::FUNC_PUSH_R: begin
                n_at_right = (i_func == bdq_pkg::FUNC_PUSH_R);
                if (w_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_status = bdq_pkg::ST_PUSHED;
                    n_item   = i_push_value;
                    n_count  = w_count_inc;
                end
            end
            bdq_pkg::FUNC_POP_L: begin
                if (w_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_status = bdq_pkg::ST_POPPED;
                    n_item   = w_cell_data[0];
                    n_count  = w_last;
                end
            end
            bdq_pkg::FUNC_POP_R: begin
                n_at_right = 1'b1;
                if (w_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_status = bdq_pkg::ST_POPPED;
                    n_item   = w_cell_data[w_last_idx];
                    n_count  = w_last;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    assign w_push_ok = w_accept && (n_status == bdq_pkg::ST_PUSHED);

    // Per-cell operation for this request
    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            w_op[k] = bdq_pkg::CELL_HOLD;
            if (w_accept) begin
                case (i_func)
                    bdq_pkg::FUNC_PUSH_L: begin
                        if (!w_full) begin
                            w_op[k] = (k == 0) ? bdq_pkg::CELL_LOAD
                                               : bdq_pkg::CELL_FROM_LEFT;
                        end
                    end
                    bdq_pkg::FUNC_PUSH_R: begin
                        if (!w_full && (r_count == bdq_pkg::CNT_W'(k))) begin
                            w_op[k] = bdq_pkg::CELL_LOAD;
                        end
                    end
                    bdq_pkg::FUNC_POP_L: begin
                        if (!w_empty) begin
                            w_op[k] = bdq_pkg::CELL_FROM_RIGHT;
                        end
                    end
                    default: begin
                        w_op[k] = bdq_pkg::CELL_HOLD;
                    end
                endcase
            end
        end
    end

    // Row of cells, each wired to its neighbors
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [bdq_pkg::DATA_W-1:0] w_left;
        logic [bdq_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_push_value;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == NCELL - 1) begin : g_last
            assign w_right = w_cell_data[g];
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end
        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op[g]),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_push_value (i_push_value),
            .o_data       (w_cell_data[g])
        );
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_at_right <= n_at_right;
            r_item     <= n_item;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_at_right   = r_at_right;
    assign o_item_value = r_item;
    assign o_occupancy  = r_count;

    // Checks
    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NCELL_C)
    `ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_accept && i_func[2], r_count == '0)
    `ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, w_push_ok, r_count == $past(w_count_inc))
    `ASSERT_IMPLY(a_full_at_cap, i_clk, i_rst_n, w_accept && n_status == bdq_pkg::ST_FULL, r_count >= w_cap_eff)

endmodule

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of the deque chain: holds one entry and takes data from
// its left or right neighbor or from the request. Uses bdq_pkg.
module bdq_cell (
    input  logic                        i_clk,
    input  bdq_pkg::t_cell_op           i_op,
    input  logic [bdq_pkg::DATA_W-1:0]  i_left_data,
    input  logic [bdq_pkg::DATA_W-1:0]  i_right_data,
    input  logic [bdq_pkg::DATA_W-1:0]  i_push_value,
    output logic [bdq_pkg::DATA_W-1:0]  o_data
);

    logic [bdq_pkg::DATA_W-1:0] r_data;
    logic [bdq_pkg::DATA_W-1:0] n_data;

    // Select the incoming entry
    always_comb begin
        case (i_op)
            bdq_pkg::CELL_FROM_LEFT:  n_data = i_left_data;
            bdq_pkg::CELL_FROM_RIGHT: n_data = i_right_data;
            bdq_pkg::CELL_LOAD:       n_data = i_push_value;
            default:                  n_data = r_data;
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== sim/tb_bounded_double_ended_queue.sv =====
// Self-checking testbench for bounded_double_ended_queue: directed corner cases, then
// random push/pop/clear traffic across several capacity settings, checked against a
// built-in deque predictor. Depends on bdq_pkg and the RTL of the block.
module tb_bounded_double_ended_queue;

    localparam int DEPTH         = bdq_pkg::DEPTH_DEF;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int OPS_PER_PHASE = 125;

    typedef struct packed {
        logic [bdq_pkg::FUNC_W-1:0]        func;
        logic signed [bdq_pkg::DATA_W-1:0] push_value;
    } t_deque_op;

    typedef struct packed {
        logic [bdq_pkg::STATUS_W-1:0]      status;
        logic                              at_right;
        logic signed [bdq_pkg::DATA_W-1:0] item_value;
        logic [bdq_pkg::CNT_W-1:0]         occupancy;
    } t_deque_result;

    // DUT inputs start at known values
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic [bdq_pkg::FUNC_W-1:0]        i_func = '0;
    logic signed [bdq_pkg::DATA_W-1:0] i_push_value = '0;
    logic                              i_out_stall = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic [bdq_pkg::CNT_W-1:0]         i_cfg_capacity = '0;

    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [bdq_pkg::STATUS_W-1:0]      o_status;
    logic                              o_at_right;
    logic signed [bdq_pkg::DATA_W-1:0] o_item_value;
    logic [bdq_pkg::CNT_W-1:0]         o_occupancy;
    logic                              o_cfg_ready;

    // Predictor state: mirror of the deque
    logic signed [bdq_pkg::DATA_W-1:0] deque_store [DEPTH];
    logic [IDX_W-1:0]                  deque_front = '0;
    logic [bdq_pkg::CNT_W-1:0]         deque_count = '0;
    logic [bdq_pkg::CNT_W-1:0]         deque_capacity = bdq_pkg::CAP_RESET;

    t_deque_op     op_backlog[$];
    t_deque_result expected_results[$];
    int            ops_issued = 0;
    int            results_checked = 0;
    int            error_count = 0;
    int            cycle_count = 0;
    int            in_gap_left = 0;
    int            out_gap_left = 0;
    bit            in_idle_on = 1'b1;
    bit            out_idle_on = 1'b1;

    bounded_double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_at_right     (o_at_right),
        .o_item_value   (o_item_value),
        .o_occupancy    (o_occupancy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the mirror and queue the result it must produce
    task automatic predict_deque_op(input logic [bdq_pkg::FUNC_W-1:0] func,
                                    input logic signed [bdq_pkg::DATA_W-1:0] value);
        t_deque_result             res;
        logic [bdq_pkg::CNT_W-1:0] limit;
        logic [IDX_W-1:0]          slot;
        limit = (deque_capacity > DEPTH) ? bdq_pkg::CNT_W'(DEPTH) : deque_capacity;
        res = '0;
        res.at_right = (func == bdq_pkg::FUNC_PUSH_R) || (func == bdq_pkg::FUNC_POP_R);
        if (func >= bdq_pkg::FUNC_CLEAR) begin
            // any code with the top bit set clears
            deque_count = '0;
            deque_front = '0;
            res.status = bdq_pkg::ST_CLEARED;
            res.at_right = 1'b0;
        end else if (func == bdq_pkg::FUNC_PUSH_L || func == bdq_pkg::FUNC_PUSH_R) begin
            if (deque_count >= limit) begin
                res.status = bdq_pkg::ST_FULL;
            end else begin
                if (res.at_right) begin
                    slot = deque_front + IDX_W'(deque_count);
                    deque_store[slot] = value;
                end else begin
                    deque_front = deque_front - 1'b1;
                    deque_store[deque_front] = value;
                end
                deque_count = deque_count + 1'b1;
                res.item_value = value;
                res.status = bdq_pkg::ST_PUSHED;
            end
        end else if (deque_count == '0) begin
            res.status = bdq_pkg::ST_EMPTY;
        end else begin
            if (res.at_right) begin
                slot = deque_front + IDX_W'(deque_count - 1'b1);
                res.item_value = deque_store[slot];
            end else begin
                res.item_value = deque_store[deque_front];
                deque_front = deque_front + 1'b1;
            end
            deque_count = deque_count - 1'b1;
            res.status = bdq_pkg::ST_POPPED;
        end
        res.occupancy = deque_count;
        expected_results = {expected_results, res};
    endtask

    function automatic void compare_field(string name, logic [bdq_pkg::DATA_W-1:0] want,
                                          logic [bdq_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    task automatic queue_op(input logic [bdq_pkg::FUNC_W-1:0] func,
                            input logic signed [bdq_pkg::DATA_W-1:0] value);
        t_deque_op op;
        op.func = func;
        op.push_value = value;
        op_backlog = {op_backlog, op};
        ops_issued++;
    endtask

    // Random traffic; push_pct sets the fill/drain tendency
    task automatic queue_random_ops(input int count, input int push_pct);
        int                                roll;
        logic [bdq_pkg::FUNC_W-1:0]        func;
        logic signed [bdq_pkg::DATA_W-1:0] value;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                func = bdq_pkg::FUNC_CLEAR | bdq_pkg::FUNC_W'($urandom_range(0, 3));
            else if (roll < 3 + push_pct)
                func = $urandom_range(0, 1) ? bdq_pkg::FUNC_PUSH_R : bdq_pkg::FUNC_PUSH_L;
            else
                func = $urandom_range(0, 1) ? bdq_pkg::FUNC_POP_R : bdq_pkg::FUNC_POP_L;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: value = 32'sh7FFF_FFFF;
                    1: value = 32'sh8000_0000;
                    2: value = '0;
                    default: value = '1;
                endcase
            end else begin
                value = $urandom();
            end
            queue_op(func, value);
        end
    endtask

    task automatic wait_drained();
        while (op_backlog.size() != 0 || results_checked != ops_issued)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [bdq_pkg::CNT_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_capacity <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        deque_capacity = cap;
    endtask

    // Request driver: one transaction per accepted edge, random gaps
    always @(posedge i_clk) begin : request_driver
        t_deque_op next_op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_deque_op(i_func, i_push_value);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (in_idle_on && $urandom_range(0, 9) == 0) begin
                    in_gap_left = $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    next_op = op_backlog[0];
                    op_backlog.delete(0);
                    i_func <= next_op.func;
                    i_push_value <= next_op.push_value;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted result, stall in random bursts
    always @(posedge i_clk) begin : result_monitor
        t_deque_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $error("unexpected result: status %0d, occupancy %0d",
                           o_status, o_occupancy);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    compare_field("status", bdq_pkg::DATA_W'(want.status),
                                  bdq_pkg::DATA_W'(o_status));
                    compare_field("at_right", bdq_pkg::DATA_W'(want.at_right),
                                  bdq_pkg::DATA_W'(o_at_right));
                    compare_field("item_value", want.item_value, o_item_value);
                    compare_field("occupancy", bdq_pkg::DATA_W'(want.occupancy),
                                  bdq_pkg::DATA_W'(o_occupancy));
                    results_checked++;
                end
            end
            if (out_gap_left > 0) begin
                out_gap_left--;
                i_out_stall <= 1'b1;
            end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
                out_gap_left = $urandom_range(0, 4);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[bounded_double_ended_queue] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int push_pct;
        logic [bdq_pkg::CNT_W-1:0] cap;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset capacity: pops on empty at both ends, extreme values
        queue_op(bdq_pkg::FUNC_POP_L, '0);
        queue_op(bdq_pkg::FUNC_POP_R, '0);
        queue_op(bdq_pkg::FUNC_PUSH_L, 32'sh7FFF_FFFF);
        queue_op(bdq_pkg::FUNC_PUSH_R, 32'sh8000_0000);
        queue_op(bdq_pkg::FUNC_PUSH_L, '0);
        queue_op(bdq_pkg::FUNC_PUSH_R, '1);
        queue_op(bdq_pkg::FUNC_POP_R, '0);
        queue_op(bdq_pkg::FUNC_POP_L, '0);
        queue_op(bdq_pkg::FUNC_POP_L, '0);
        queue_op(bdq_pkg::FUNC_POP_R, '0);
        // codes above clear also clear
        queue_op(bdq_pkg::FUNC_PUSH_R, 32'sh5555_5555);
        queue_op(bdq_pkg::FUNC_CLEAR | 3'd1, '1);
        queue_op(bdq_pkg::FUNC_PUSH_L, 32'shAAAA_AAAA);
        queue_op(bdq_pkg::FUNC_CLEAR | 3'd2, '0);
        queue_op(bdq_pkg::FUNC_CLEAR | 3'd3, '1);
        queue_op(bdq_pkg::FUNC_CLEAR, '0);
        queue_op(bdq_pkg::FUNC_PUSH_R, 32'sh1234_5678);
        queue_op(bdq_pkg::FUNC_PUSH_L, -32'sd2);
        queue_op(bdq_pkg::FUNC_PUSH_R, 32'sh0F0F_0F0F);
        queue_op(bdq_pkg::FUNC_PUSH_L, 32'shF0F0_F0F0);
        wait_drained();

        // Capacity lowered below the held count: entries stay, pushes refused until pops bring it under
        write_capacity(5'd2);
        queue_op(bdq_pkg::FUNC_PUSH_L, 32'sh1111_1111);
        queue_op(bdq_pkg::FUNC_POP_L, '0);
        queue_op(bdq_pkg::FUNC_POP_R, '0);
        queue_op(bdq_pkg::FUNC_PUSH_R, 32'sh2222_2222);
        queue_op(bdq_pkg::FUNC_POP_L, '0);
        queue_op(bdq_pkg::FUNC_PUSH_R, 32'sh3333_3333);
        wait_drained();

        // Random phases over a spread of capacities, zero and above depth included
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: cap = 5'd16;
                1: cap = 5'd1;
                2: cap = 5'd0;
                3: cap = 5'd31;
                4: cap = 5'd5;
                6: cap = bdq_pkg::CNT_W'($urandom_range(2, 15));
                7: cap = 5'd8;
                8: cap = bdq_pkg::CNT_W'($urandom_range(0, 31));
                default: cap = 5'd16;
            endcase
            write_capacity(cap);
            push_pct = (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 48 : 30);
            if (p == RANDOM_PHASES - 1) begin
                in_idle_on = 1'b0;
                out_idle_on = 1'b0;
            end else begin
                in_idle_on = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            queue_random_ops(OPS_PER_PHASE, push_pct);
            wait_drained();
        end

        repeat (5) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[bounded_double_ended_queue] OK");
        end else begin
            $display("[bounded_double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule

// ===== bounded_double_ended_queue.f =====
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_double_ended_queue.sv
sim/tb_bounded_double_ended_queue.sv
